@@ rtl/core/dfcc_pkg.sv @@
// Package for the dual frame checker and classifier: frame and message codes,
// message kinds and the frame view handed from the collector to the classifier.
// No dependencies.
`timescale 1ns / 1ps

package dfcc_pkg;

  localparam logic [7:0] GW_START     = 8'h68;
  localparam logic [7:0] GW_STOP      = 8'h16;
  localparam logic [7:0] MOD_START    = 8'hA5;
  localparam logic [7:0] MOD_STOP     = 8'h5A;
  localparam logic [7:0] CMD_HEARTBT  = 8'h02;
  localparam logic [7:0] CMD_ID       = 8'hA2;
  localparam logic [7:0] SUB_HEARTBT  = 8'hF1;
  localparam logic [7:0] SUB_ID_ASSGN = 8'hF2;
  localparam logic [7:0] SUB_ID_CONF  = 8'hF4;
  localparam logic [7:0] MOD_ID_TAG   = 8'h84;

  localparam int unsigned HEAD_DEPTH = 8;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_HEARTBEAT,
    KIND_GW_ID,
    KIND_ID_CONFIRM,
    KIND_MODULE_ID
  } msg_kind_t;

  // Frame contents as they stand once the current byte has been taken in.
  typedef struct packed {
    logic [HEAD_DEPTH-1:0][7:0] head;
    logic [7:0]                 sum;        // sum of all bytes but the last two
    logic [7:0]                 cs;         // the byte before the current one
    logic [7:0]                 rx_byte;    // the current byte
    logic                       overflow;
    logic                       gw_len_ok;
    logic                       mod_len_ok;
  } frame_view_t;

endpackage

@@ rtl/core/dfcc_collect.sv @@
// Frame collector: byte count, first eight bytes, running sum and the two most
// recent bytes of the current frame. Depends on dfcc_pkg.
`timescale 1ns / 1ps

module dfcc_collect #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_end,
  output dfcc_pkg::frame_view_t view
);
  import dfcc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FRAME + 2);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME);

  logic [CW-1:0]                 byte_count;
  logic [CW-1:0]                 byte_count_next;
  logic [HEAD_DEPTH-1:0][7:0]    head;
  logic [HEAD_DEPTH-1:0][7:0]    head_next;
  logic [7:0]                    sum;
  logic [7:0]                    sum_next;
  logic [7:0]                    prev_byte;
  logic [7:0]                    prev_prev_byte;
  logic                          overflow;
  logic                          overflow_next;

  always_comb begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_next[i] = (byte_count == CW'(i)) ? rx_byte : head[i];
    end
    sum_next = (byte_count >= CW'(2)) ? sum + prev_prev_byte : sum;
    byte_count_next = (byte_count <= MAX_CNT) ? byte_count + CW'(1) : byte_count;
    overflow_next = overflow || (byte_count_next > MAX_CNT);
  end

  always_comb begin
    view.head       = head_next;
    view.sum        = sum_next;
    view.cs         = prev_byte;
    view.rx_byte    = rx_byte;
    view.overflow   = overflow_next;
    view.gw_len_ok  = (10'(head_next[2]) + 10'd5) == 10'(byte_count_next);
    view.mod_len_ok = (10'(head_next[1]) + 10'd4) == 10'(byte_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      head           <= '0;
      sum            <= '0;
      prev_byte      <= '0;
      prev_prev_byte <= '0;
      overflow       <= 1'b0;
    end else if (step) begin
      if (frame_end) begin
        byte_count     <= '0;
        head           <= '0;
        sum            <= '0;
        prev_byte      <= '0;
        prev_prev_byte <= '0;
        overflow       <= 1'b0;
      end else begin
        byte_count     <= byte_count_next;
        head           <= head_next;
        sum            <= sum_next;
        prev_byte      <= rx_byte;
        prev_prev_byte <= prev_byte;
        overflow       <= overflow_next;
      end
    end
  end

endmodule

@@ rtl/core/dfcc_classify.sv @@
// Frame classifier: checks the gateway and module formats at frame end, keeps
// the held IDs and drives the result register. Depends on dfcc_pkg.
`timescale 1ns / 1ps

module dfcc_classify (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  dfcc_pkg::frame_view_t view,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [2:0]            msg_kind,
  output logic [31:0]           gateway_id,
  output logic [15:0]           module_id,
  output logic                  too_long
);
  import dfcc_pkg::*;

  logic [31:0] held_gateway_id;
  logic [31:0] held_gateway_id_next;
  logic [15:0] held_module_id;
  logic [15:0] held_module_id_next;
  msg_kind_t   kind;
  logic        gw_ok;
  logic        mod_ok;
  logic [7:0]  mod_sum;

  always_comb begin
    mod_sum = view.sum - view.head[0] - view.head[1];
    gw_ok = !view.overflow && view.head[0] == GW_START && view.gw_len_ok &&
            view.rx_byte == GW_STOP && view.sum == view.cs;
    mod_ok = !view.overflow && view.head[0] == MOD_START && view.mod_len_ok &&
             view.rx_byte == MOD_STOP && mod_sum == view.cs;
    kind = KIND_NONE;
    held_gateway_id_next = held_gateway_id;
    held_module_id_next  = held_module_id;
    // A valid gateway frame of unknown type does not fall through to the module check.
    if (gw_ok) begin
      if (view.head[1] == CMD_HEARTBT && view.head[3] == SUB_HEARTBT) begin
        kind = KIND_HEARTBEAT;
      end else if (view.head[1] == CMD_ID && view.head[3] == SUB_ID_ASSGN) begin
        kind = KIND_GW_ID;
        held_gateway_id_next = {view.head[4], view.head[5], view.head[6], view.head[7]};
      end else if (view.head[1] == CMD_ID && view.head[3] == SUB_ID_CONF) begin
        kind = KIND_ID_CONFIRM;
      end
    end else if (mod_ok && view.head[2] == MOD_ID_TAG) begin
      kind = KIND_MODULE_ID;
      held_module_id_next = {view.head[4], view.head[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_gateway_id <= '0;
      held_module_id  <= '0;
      out_valid       <= 1'b0;
    end else if (load) begin
      held_gateway_id <= held_gateway_id_next;
      held_module_id  <= held_module_id_next;
      out_valid       <= 1'b1;
    end else if (out_ready) begin
      out_valid       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      msg_kind   <= kind;
      gateway_id <= held_gateway_id_next;
      module_id  <= held_module_id_next;
      too_long   <= view.overflow;
    end
  end

endmodule

@@ rtl/core/dual_frame_checker_classifier_top.sv @@
// Top level of the dual frame checker and classifier: input register and
// stream handshakes around dfcc_collect and dfcc_classify. Depends on dfcc_pkg.
`timescale 1ns / 1ps

// Usage:
// Received bytes enter on the s_ channel, one byte per request, with s_tlast
// set on the last byte of a frame. Each frame end gives one result request on
// the m_ channel: message kind, held gateway ID, held module ID and the
// too-long flag. Bytes that are not a frame end give no result.
// Throughput is one byte per cycle unless a frame-end byte waits on a stalled
// receiver: each byte passes through the input register, and the collector
// and classifier then take it in; a frame-end byte loads the result register,
// which drives m_tvalid.
// When the receiver stalls, the result register holds its request; further
// non-final bytes are still taken, and a frame-end byte waits in the input
// register until the result register is free.
// Reset clears the frame state, the held IDs and both valid flags; the block
// accepts bytes in the first cycle after reset.
module dual_frame_checker_classifier_top #(
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [2:0] msg_kind, [34:3] gateway_id, [50:35] module_id
  output logic        m_tuser    // too_long
);
  import dfcc_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        step;
  logic        load;
  frame_view_t view;
  logic [2:0]  msg_kind;
  logic [31:0] gateway_id;
  logic [15:0] module_id;

  // A non-final byte never needs the result register, so it moves on at once.
  assign step     = in_valid && (!in_last || !m_tvalid || m_tready);
  assign load     = step && in_last;
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  dfcc_collect #(
    .MAX_FRAME (MAX_FRAME)
  ) u_collect (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (in_byte),
    .frame_end (in_last),
    .view      (view)
  );

  dfcc_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .view       (view),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .msg_kind   (msg_kind),
    .gateway_id (gateway_id),
    .module_id  (module_id),
    .too_long   (m_tuser)
  );

  assign m_tdata = {5'b0, module_id, gateway_id, msg_kind};

endmodule

@@ tb/sv/dual_frame_checker_classifier_top_test.sv @@
// Self-checking test of dual_frame_checker_classifier_top: directed and random byte frames
// with random idling on both sides, checked against a scoreboard class that predicts results.
// Depends on dfcc_pkg and the top level of the block.
`timescale 1ns / 1ps

module dual_frame_checker_classifier_top_test;
  import dfcc_pkg::*;

  localparam int MAX_FRAME   = 32;
  localparam int ITEM_TARGET = 1200;
  localparam int PHASE_ITEMS = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 10;

  typedef bit [7:0] byte_q_t[$];

  typedef struct {
    msg_kind_t  kind;
    bit [31:0]  gw_id;
    bit [15:0]  mod_id;
    bit         too_long;
  } frame_result_t;

  // Tracks the frame state of the block and holds the results still to come.
  class frame_scoreboard;
    bit [5:0]      byte_count;
    bit [7:0]      head [HEAD_DEPTH];
    bit [7:0]      run_sum;
    bit [7:0]      last_byte;
    bit [7:0]      older_byte;
    bit            overflow;
    bit [31:0]     gw_id;
    bit [15:0]     mod_id;
    frame_result_t awaited[$];
    int            errors;

    function new();
      clear_frame();
      gw_id  = '0;
      mod_id = '0;
      errors = 0;
    endfunction

    function void clear_frame();
      byte_count = '0;
      foreach (head[i]) head[i] = '0;
      run_sum    = '0;
      last_byte  = '0;
      older_byte = '0;
      overflow   = 1'b0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      frame_result_t r;
      bit [7:0]      cs;
      bit [7:0]      payload_sum;
      int            len;
      if (byte_count < HEAD_DEPTH) head[byte_count] = b;
      // The running sum lags two bytes behind, so it never holds checksum or stop byte.
      if (byte_count >= 2) run_sum += older_byte;
      if (byte_count <= MAX_FRAME) byte_count++;
      if (byte_count > MAX_FRAME) overflow = 1'b1;
      cs         = last_byte;
      older_byte = last_byte;
      last_byte  = b;
      if (!last) return;

      len         = byte_count;
      payload_sum = run_sum - head[0] - head[1];
      r.kind      = KIND_NONE;
      if (!overflow) begin
        if (head[0] == GW_START && int'(head[2]) + 5 == len && b == GW_STOP &&
            run_sum == cs) begin
          if (head[1] == CMD_HEARTBT && head[3] == SUB_HEARTBT) r.kind = KIND_HEARTBEAT;
          if (head[1] == CMD_ID && head[3] == SUB_ID_ASSGN) begin
            gw_id  = {head[4], head[5], head[6], head[7]};
            r.kind = KIND_GW_ID;
          end
          if (head[1] == CMD_ID && head[3] == SUB_ID_CONF) r.kind = KIND_ID_CONFIRM;
        end else if (head[0] == MOD_START && int'(head[1]) + 4 == len && b == MOD_STOP &&
                     payload_sum == cs) begin
          if (head[2] == MOD_ID_TAG) begin
            mod_id = {head[4], head[3]};
            r.kind = KIND_MODULE_ID;
          end
        end
      end
      r.gw_id    = gw_id;
      r.mod_id   = mod_id;
      r.too_long = overflow;
      awaited.push_back(r);
      clear_frame();
    endfunction

    function void check_result(logic [55:0] data, logic tl);
      frame_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: result request with none expected: tdata %h tuser %b", $time, data, tl);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (data[2:0] !== e.kind) begin
        $display("%0t: msg_kind expected %0d actual %0d", $time, e.kind, data[2:0]);
        errors++;
      end
      if (data[34:3] !== e.gw_id) begin
        $display("%0t: gateway_id expected %h actual %h", $time, e.gw_id, data[34:3]);
        errors++;
      end
      if (data[50:35] !== e.mod_id) begin
        $display("%0t: module_id expected %h actual %h", $time, e.mod_id, data[50:35]);
        errors++;
      end
      if (tl !== e.too_long) begin
        $display("%0t: too_long expected %b actual %b", $time, e.too_long, tl);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        m_tuser;

  frame_scoreboard sb;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              item_count;
  int              cycle_count;

  dual_frame_checker_classifier_top #(
    .MAX_FRAME(MAX_FRAME)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Receiver side: random back-pressure, set at each falling edge.
  initial begin
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1)
        sb.check_result(m_tdata, m_tuser);
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(input bit [7:0] b, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_byte(b, last);
    item_count++;
    @(negedge clk);
  endtask

  task automatic send_frame(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic int pick_len(int lo, int usual_hi, int hi);
    if ($urandom_range(9) != 0) return $urandom_range(usual_hi, lo);
    return $urandom_range(hi, lo);
  endfunction

  // A fill below zero gives random data bytes, otherwise every data byte is the fill.
  function automatic byte_q_t build_gateway(bit [7:0] cmd, int len, bit [7:0] sub, int fill);
    byte_q_t  q;
    bit [7:0] cs;
    q = {};
    q.push_back(GW_START);
    q.push_back(cmd);
    q.push_back(len[7:0]);
    for (int i = 0; i < len; i++)
      q.push_back(i == 0 ? sub : (fill < 0 ? 8'($urandom) : fill[7:0]));
    cs = '0;
    foreach (q[i]) cs += q[i];
    q.push_back(cs);
    q.push_back(GW_STOP);
    return q;
  endfunction

  function automatic byte_q_t build_module(int len, bit [7:0] tag, int fill);
    byte_q_t  q;
    bit [7:0] cs;
    bit [7:0] d;
    q  = {};
    cs = '0;
    q.push_back(MOD_START);
    q.push_back(len[7:0]);
    for (int i = 0; i < len; i++) begin
      d = (i == 0) ? tag : (fill < 0 ? 8'($urandom) : fill[7:0]);
      cs += d;
      q.push_back(d);
    end
    q.push_back(cs);
    q.push_back(MOD_STOP);
    return q;
  endfunction

  function automatic byte_q_t random_bytes(int len, bit [7:0] first);
    byte_q_t q;
    q = {};
    q.push_back(first);
    for (int i = 1; i < len; i++) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic byte_q_t random_frame();
    byte_q_t q;
    int      pick;
    int      pos;
    bit [7:0] first;
    pick = $urandom_range(99);
    if (pick < 12)
      q = build_gateway(CMD_HEARTBT, pick_len(1, 6, 27), SUB_HEARTBT, -1);
    else if (pick < 28)
      q = build_gateway(CMD_ID, $urandom_range(4) == 0 ? pick_len(1, 4, 27) : pick_len(5, 10, 27),
                        SUB_ID_ASSGN, -1);
    else if (pick < 40)
      q = build_gateway(CMD_ID, pick_len(1, 6, 27), SUB_ID_CONF, -1);
    else if (pick < 60)
      q = build_module($urandom_range(4) == 0 ? pick_len(0, 4, 28) : pick_len(3, 8, 28),
                       MOD_ID_TAG, -1);
    else if (pick < 68)
      q = build_gateway(8'($urandom), pick_len(0, 8, 27), 8'($urandom), -1);
    else if (pick < 75)
      q = build_module(pick_len(0, 8, 28), 8'($urandom), -1);
    else if (pick < 87) begin
      // A well-formed frame with one fault: a flipped bit, a lost byte or an extra byte.
      q = $urandom_range(1) ? build_gateway(CMD_ID, pick_len(1, 8, 27), SUB_ID_ASSGN, -1)
                            : build_module(pick_len(3, 8, 28), MOD_ID_TAG, -1);
      pos = $urandom_range(q.size() - 1);
      case ($urandom_range(2))
        0:       q[pos] ^= 8'(1 << $urandom_range(7));
        1:       q.delete(pos);
        default: q.insert(pos, 8'($urandom));
      endcase
    end else if (pick < 96)
      q = random_bytes($urandom_range(12, 1), 8'($urandom));
    else begin
      first = ($urandom_range(2) == 0) ? GW_START : (($urandom_range(1) == 0) ? MOD_START
                                                                             : 8'($urandom));
      q = random_bytes($urandom_range(1) ? $urandom_range(34, 32) : $urandom_range(45, 32),
                       first);
    end
    return q;
  endfunction

  initial begin
    int phase;
    int next_phase;
    byte_q_t q;
    sb             = new();
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    m_tready       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    item_count     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames: each message kind, all-ones IDs and a one-byte frame.
    send_frame(build_gateway(CMD_HEARTBT, 1, SUB_HEARTBT, 0));
    send_frame(build_gateway(CMD_ID, 5, SUB_ID_ASSGN, 8'hFF));
    send_frame(build_gateway(CMD_ID, 1, SUB_ID_CONF, -1));
    send_frame(build_module(3, MOD_ID_TAG, 8'hFF));
    send_byte(8'hFF, 1'b1);
    wait_drained();

    phase = 0;
    while (item_count < ITEM_TARGET) begin
      next_phase = (item_count / PHASE_ITEMS) % 4;
      if (next_phase != phase) begin
        // Let the block empty out before the idling pattern changes.
        wait_drained();
        phase = next_phase;
        case (phase)
          0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
          default: begin send_idle_pct = 16; recv_stall_pct = 16; end
        endcase
      end
      q = random_frame();
      send_frame(q);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/dfcc_pkg.sv
rtl/core/dfcc_collect.sv
rtl/core/dfcc_classify.sv
rtl/core/dual_frame_checker_classifier_top.sv
tb/sv/dual_frame_checker_classifier_top_test.sv
